/* sv/lwsl_pkg.sv */
// Shared constants, types and helpers for the longest-window-sum block.
// No dependencies; imported by the top level.
package lwsl_pkg;

   localparam int WINDOW_DEPTH = 1024;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int SAMPLE_W     = 16;
   localparam int SUM_W        = 48;
   localparam int LEN_W        = 11;

   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_LSB  = 3;
   localparam int CSR_ADDR_W   = CSR_IDX_LSB + 1;
   localparam int CSR_IDX_W    = CSR_ADDR_W - CSR_IDX_LSB;

   localparam logic [CSR_IDX_W-1:0] REG_SUM_LIMIT = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_PUSH,
      ST_POP,
      ST_DONE
   } state_type;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] nxt;
      nxt = (slot == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;
      return nxt;
   endfunction

   function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[LEN_W-1:0];
   endfunction

endpackage

/* sv/longest_window_sum_at_most_limit.sv */
// Longest window with sum at most a limit: top level, control and datapath.
// Depends on lwsl_pkg and lwsl_ram (window buffer).
//
// Usage:
//   req channel carries sample_value and start_new; rsp channel returns one
//   result per sample: best_length, window_length and overflow. Both use
//   valid/stall; a transfer happens when valid is high and stall is low.
//   csr port holds sum_limit at byte address 0 (64-bit data, low 48 bits).
//   Write sum_limit only while no sample is in flight.
// Sequencing:
//   An item is taken in ST_IDLE; a full buffer adds ST_DROP and ST_PUSH, and
//   ST_POP is entered once per value popped from the window; each pop is one
//   read of the window buffer through its single read port. req_stall is high
//   from the transfer until the result is placed in the output register.
// Reset: synchronous; empties the window, clears best length and sum_limit.
//   Buffer contents are not cleared and need no clearing pass.
// Receiver stall: the result waits in the output register; the next sample
//   is still taken and runs until its own result is ready, then holds.
module longest_window_sum_at_most_limit
   import lwsl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_sample_value,
   input  logic                  req_start_new,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [LEN_W-1:0]      rsp_best_length,
   output logic [LEN_W-1:0]      rsp_window_length,
   output logic                  rsp_overflow,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    best_ff, best_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                ovf_ff, ovf_in;
   logic [SUM_W-1:0]    limit_ff, limit_in;
   logic                fwd_ff, fwd_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]    rsp_best_ff, rsp_best_in;
   logic [LEN_W-1:0]    rsp_win_ff, rsp_win_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [SAMPLE_W-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;

   logic                accept;
   logic                start_clr;
   logic                out_free;
   logic                csr_wr;
   logic [IDX_W-1:0]    head_b, tail_b, tail_nx;
   logic [CNT_W-1:0]    cnt_b, best_b, push_cnt, pop_cnt;
   logic [SUM_W-1:0]    sum_b, push_sum, pop_sum;
   logic [SAMPLE_W-1:0] push_val, pop_val;
   logic                full_b, push_over, pop_over;

   lwsl_ram #(
      .DATA_W (SAMPLE_W),
      .DEPTH  (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared arithmetic
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign start_clr = accept && req_start_new;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign head_b = start_clr ? '0 : head_ff;
   assign tail_b = start_clr ? '0 : tail_ff;
   assign cnt_b  = start_clr ? '0 : cnt_ff;
   assign sum_b  = start_clr ? '0 : sum_ff;
   assign best_b = start_clr ? '0 : best_ff;
   assign full_b = (cnt_b == CNT_W'(WINDOW_DEPTH));

   assign push_val  = (state_ff == ST_IDLE) ? req_sample_value : sample_ff;
   assign push_sum  = sum_b + SUM_W'(push_val);
   assign push_cnt  = cnt_b + 1'b1;
   assign push_over = (push_sum > limit_ff);

   // forward the sample written to the slot being read in the same cycle
   assign pop_val  = fwd_ff ? sample_ff : ram_rd_data;
   assign pop_sum  = sum_ff - SUM_W'(pop_val);
   assign pop_cnt  = cnt_ff - 1'b1;
   assign tail_nx  = next_slot(tail_ff);
   assign pop_over = (pop_sum > limit_ff) && (pop_cnt != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full_b) begin
                  state_in = ST_DROP;
               end else if (push_over) begin
                  state_in = ST_POP;
               end else if (!out_free) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DROP: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (push_over) begin
               state_in = ST_POP;
            end else begin
               state_in = out_free ? ST_IDLE : ST_DONE;
            end
         end
         ST_POP: begin
            if (pop_over) begin
               state_in = ST_POP;
            end else begin
               state_in = out_free ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = out_free ? ST_IDLE : ST_DONE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic             finish;
      logic [CNT_W-1:0] fin_cnt;
      logic [CNT_W-1:0] fin_best;
      logic             fin_ovf;
      logic             do_push;

      finish      = 1'b0;
      fin_cnt     = cnt_ff;
      fin_best    = best_ff;
      fin_ovf     = ovf_ff;
      do_push     = 1'b0;

      head_in     = head_ff;
      tail_in     = tail_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      best_in     = best_ff;
      sample_in   = sample_ff;
      ovf_in      = ovf_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = head_b;
      ram_wr_data = push_val;
      ram_rd_en   = 1'b0;
      ram_rd_addr = tail_b;

      rsp_best_in = rsp_best_ff;
      rsp_win_in  = rsp_win_ff;
      rsp_ovf_in  = rsp_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample_value;
               ovf_in    = full_b;
               fin_ovf   = full_b;
               head_in   = head_b;
               tail_in   = tail_b;
               cnt_in    = cnt_b;
               sum_in    = sum_b;
               best_in   = best_b;
               if (full_b) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = tail_b;
               end else begin
                  do_push = 1'b1;
               end
            end
         end
         ST_DROP: begin
            sum_in  = pop_sum;
            tail_in = tail_nx;
            cnt_in  = pop_cnt;
         end
         ST_PUSH: begin
            do_push = 1'b1;
         end
         ST_POP: begin
            sum_in  = pop_sum;
            tail_in = tail_nx;
            cnt_in  = pop_cnt;
            if (pop_over) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = tail_nx;
            end else begin
               finish  = 1'b1;
               fin_cnt = pop_cnt;
            end
         end
         ST_DONE: begin
            finish = 1'b1;
         end
         default: begin
            finish = 1'b0;
         end
      endcase

      if (do_push) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = head_b;
         ram_wr_data = push_val;
         head_in     = next_slot(head_b);
         cnt_in      = push_cnt;
         sum_in      = push_sum;
         if (push_over) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = tail_b;
         end else begin
            finish  = 1'b1;
            fin_cnt = push_cnt;
         end
      end

      if (finish) begin
         fin_best = (fin_cnt > best_b) ? fin_cnt : best_b;
         best_in  = fin_best;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_best_in  = to_len(fin_best);
         rsp_win_in   = to_len(fin_cnt);
         rsp_ovf_in   = fin_ovf;
      end
   end

   assign fwd_in = ram_rd_en && ram_wr_en && (ram_rd_addr == ram_wr_addr);

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      limit_in = limit_ff;
      if (csr_wr && (csr_paddr[CSR_ADDR_W-1:CSR_IDX_LSB] == REG_SUM_LIMIT)) begin
         limit_in = csr_pwdata[SUM_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:CSR_IDX_LSB] == REG_SUM_LIMIT) begin
         csr_prdata = CSR_DATA_W'(limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         best_ff      <= '0;
         limit_ff     <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         best_ff      <= best_in;
         limit_ff     <= limit_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      ovf_ff      <= ovf_in;
      rsp_best_ff <= rsp_best_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_length   = rsp_best_ff;
   assign rsp_window_length = rsp_win_ff;
   assign rsp_overflow      = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("window count above buffer depth");

   a_best_cover: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (best_ff >= cnt_ff))
      else $error("best length below current window length");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (sum_ff == '0))
      else $error("empty window with nonzero sum");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> (cnt_ff != '0))
      else $error("pop from empty window");
`endif

endmodule

/* sv/lwsl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lwsl_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
